FILE: design/modem_response_matcher_core_macros.svh
// Assertion macros used by the modem response matcher line capture module
`ifndef MODEM_RESPONSE_MATCHER_CORE_MACROS_SVH
`define MODEM_RESPONSE_MATCHER_CORE_MACROS_SVH

// Check that a condition implies another condition in the same cycle
`define MRM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition implies another condition in the next cycle
`define MRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/mrm_pkg.sv
// Types and constants for the modem response matcher
package mrm_pkg;

    localparam int WIN_LEN   = 22;
    localparam int POS_OUT_W = 9;

    // Operation codes
    localparam logic OP_RX  = 1'b0;
    localparam logic OP_ACK = 1'b1;

    // Characters
    localparam logic [7:0] CH_PROMPT = 8'h3E;  // '>'
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Fixed strings, first character in the top byte
    localparam logic [47:0] STR_READY  = 48'h20_52_65_61_64_79;    // " Ready"
    localparam logic [39:0] STR_CREG   = 40'h43_52_45_47_3A;       // "CREG:"
    localparam logic [55:0] STR_CMT    = 56'h2B_43_4D_54_3A_20_22; // "+CMT: \""

    // Second CR of a line
    localparam logic [1:0] CR_LINE_END = 2'd2;

    // Match window, element WIN_LEN-1 is the newest byte
    typedef logic [WIN_LEN-1:0][7:0] t_window;

    typedef struct packed {
        logic        prompt_seen;
        logic        ok_seen;
        logic        call_ready_seen;
        logic        registered_seen;
        logic        phone_captured;
        logic [63:0] phone_chars_first;
        logic [23:0] phone_chars_rest;
    } t_scan;

    typedef struct packed {
        logic                 line_byte_valid;
        logic [POS_OUT_W-1:0] line_position;
        logic [7:0]           line_byte;
        logic                 sms_line_done;
    } t_line_out;

    typedef struct packed {
        t_scan     scan;
        t_line_out line;
    } t_result;

endpackage

FILE: design/mrm_scan.sv
// Pattern compares and caller number extraction over the shifted window
module mrm_scan (
    input  mrm_pkg::t_window i_window,
    input  logic             i_enable,
    output mrm_pkg::t_scan   o_scan
);

    logic header;
    logic national;
    logic intl;

    // Match the message header and the two number formats
    assign header   = ({i_window[0], i_window[1], i_window[2], i_window[3],
                        i_window[4], i_window[5], i_window[6]} == mrm_pkg::STR_CMT);
    assign national = header && (i_window[18] == mrm_pkg::CH_QUOTE);
    assign intl     = header && (i_window[21] == mrm_pkg::CH_QUOTE)
                      && (i_window[7] == mrm_pkg::CH_PLUS);

    // Flag the fixed responses and pack the number, international first
    always_comb begin
        o_scan = '0;
        if (i_enable) begin
            o_scan.prompt_seen     = (i_window[21] == mrm_pkg::CH_PROMPT);
            o_scan.ok_seen         = (i_window[18] == mrm_pkg::CH_O)
                                     && (i_window[19] == mrm_pkg::CH_K);
            o_scan.call_ready_seen = ({i_window[14], i_window[15], i_window[16],
                                       i_window[17], i_window[18], i_window[19]}
                                      == mrm_pkg::STR_READY);
            o_scan.registered_seen = ({i_window[11], i_window[12], i_window[13],
                                       i_window[14], i_window[15]} == mrm_pkg::STR_CREG)
                                     && ((i_window[19] == mrm_pkg::CH_ONE)
                                         || (i_window[19] == mrm_pkg::CH_FIVE));
            o_scan.phone_captured  = intl || national;
            if (intl) begin
                o_scan.phone_chars_first = {i_window[10], i_window[11], i_window[12],
                                            i_window[13], i_window[14], i_window[15],
                                            i_window[16], i_window[17]};
                o_scan.phone_chars_rest  = {i_window[18], i_window[19], i_window[20]};
            end else if (national) begin
                o_scan.phone_chars_first = {i_window[7], i_window[8], i_window[9],
                                            i_window[10], i_window[11], i_window[12],
                                            i_window[13], i_window[14]};
                o_scan.phone_chars_rest  = {i_window[15], i_window[16], i_window[17]};
            end
        end
    end

endmodule

FILE: design/mrm_line.sv
// Message line capture: arming, CR counting, byte indexing and pending flag
`include "modem_response_matcher_core_macros.svh"

module mrm_line #(
    parameter int LINE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_op,
    input  logic [7:0]         i_byte,
    input  logic               i_phone_hit,
    output mrm_pkg::t_line_out o_line
);

    localparam int                POS_W   = $clog2(LINE_DEPTH + 1);
    localparam logic [POS_W-1:0] DEPTH_L = POS_W'(LINE_DEPTH);

    logic             r_armed,    n_armed;
    logic             r_pending,  n_pending;
    logic [1:0]       r_cr_count, n_cr_count;
    logic             r_in_line,  n_in_line;
    logic [POS_W-1:0] r_line_pos, n_line_pos;
    logic [1:0]       cr_inc;

    assign cr_inc = r_cr_count + 2'd1;

    // Work out the next capture state and this transaction's line output
    always_comb begin
        n_armed    = r_armed;
        n_pending  = r_pending;
        n_cr_count = r_cr_count;
        n_in_line  = r_in_line;
        n_line_pos = r_line_pos;
        o_line     = '0;
        if (i_op == mrm_pkg::OP_ACK) begin
            n_pending = 1'b0;
        end else begin
            if (i_phone_hit) begin
                n_armed = 1'b1;
            end
            if (n_armed && !r_pending) begin
                if (i_byte == mrm_pkg::CH_CR) begin
                    if (cr_inc == mrm_pkg::CR_LINE_END) begin
                        n_cr_count           = '0;
                        n_armed              = 1'b0;
                        n_in_line            = 1'b0;
                        n_pending            = 1'b1;
                        o_line.sms_line_done = 1'b1;
                        o_line.line_position = mrm_pkg::POS_OUT_W'(r_line_pos);
                    end else begin
                        n_cr_count = cr_inc;
                    end
                end else if (i_byte == mrm_pkg::CH_LF) begin
                    n_line_pos = '0;
                    n_in_line  = 1'b1;
                end else if (r_in_line) begin
                    if (r_line_pos < DEPTH_L) begin
                        o_line.line_byte_valid = 1'b1;
                        o_line.line_position   = mrm_pkg::POS_OUT_W'(r_line_pos);
                        o_line.line_byte       = i_byte;
                        n_line_pos             = r_line_pos + POS_W'(1);
                    end else begin
                        // Overflow: drop the byte and abort the line
                        n_in_line  = 1'b0;
                        n_cr_count = '0;
                    end
                end
            end
        end
    end

    // Advance state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_pending  <= 1'b0;
            r_cr_count <= '0;
            r_in_line  <= 1'b0;
            r_line_pos <= '0;
        end else if (i_en) begin
            r_armed    <= n_armed;
            r_pending  <= n_pending;
            r_cr_count <= n_cr_count;
            r_in_line  <= n_in_line;
            r_line_pos <= n_line_pos;
        end
    end

    `MRM_ASSERT_NEXT(a_done_sets_pending, i_clk, i_rst_n, i_en && o_line.sms_line_done, r_pending && !r_armed)
    `MRM_ASSERT_SAME(a_line_not_pending, i_clk, i_rst_n, r_in_line, !r_pending)
    `MRM_ASSERT_SAME(a_byte_or_done, i_clk, i_rst_n, o_line.line_byte_valid, !o_line.sms_line_done)

endmodule

FILE: design/mrm_outbuf.sv
// Result register with a skid stage so input is taken while a result waits
module mrm_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  mrm_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output mrm_pkg::t_result o_data,
    input  logic             i_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    mrm_pkg::t_result r_out;
    mrm_pkg::t_result r_skid;
    logic             push;
    logic             pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_out_valid && i_ready;

    // Control: refill the result register from skid first, then from input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: move data alongside the control
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= i_data;
            end
        end else if (push) begin
            r_skid <= i_data;
        end
    end

endmodule

FILE: design/modem_response_matcher_core.sv
// An accepted transaction's result is registered in the result register, or held in the skid
// stage while a stalled result still holds the result register.
// Throughput: one transaction per cycle while o_in_ready is high; window shift, compares
// and line capture all complete in one pass into a result register backed by a skid stage.
// o_in_ready drops only while both the result register and skid stage are full.
// Reset (synchronous, active low) zeroes the window, clears capture state, empties the buffer.
module modem_response_matcher_core #(
    parameter int LINE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_prompt_seen,
    output logic        o_ok_seen,
    output logic        o_call_ready_seen,
    output logic        o_registered_seen,
    output logic        o_phone_captured,
    output logic [63:0] o_phone_chars_first,
    output logic [23:0] o_phone_chars_rest,
    output logic        o_line_byte_valid,
    output logic [8:0]  o_line_position,
    output logic [7:0]  o_line_byte,
    output logic        o_sms_line_done
);

    mrm_pkg::t_window   r_window;
    mrm_pkg::t_window   n_window;
    mrm_pkg::t_scan     scan;
    mrm_pkg::t_line_out line_out;
    mrm_pkg::t_result   result;
    mrm_pkg::t_result   out_data;
    logic               accept;
    logic               is_rx;

    assign accept   = i_in_valid && o_in_ready;
    assign is_rx    = (i_op == mrm_pkg::OP_RX);
    assign n_window = {i_rx_byte, r_window[mrm_pkg::WIN_LEN-1:1]};

    // Shift the received byte into the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (accept && is_rx) begin
            r_window <= n_window;
        end
    end

    mrm_scan u_scan (
        .i_window (n_window),
        .i_enable (is_rx),
        .o_scan   (scan)
    );

    mrm_line #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_op        (i_op),
        .i_byte      (i_rx_byte),
        .i_phone_hit (scan.phone_captured),
        .o_line      (line_out)
    );

    assign result.scan = scan;
    assign result.line = line_out;

    mrm_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_ready (i_out_ready)
    );

    // Unpack the result transaction onto the ports
    assign o_prompt_seen       = out_data.scan.prompt_seen;
    assign o_ok_seen           = out_data.scan.ok_seen;
    assign o_call_ready_seen   = out_data.scan.call_ready_seen;
    assign o_registered_seen   = out_data.scan.registered_seen;
    assign o_phone_captured    = out_data.scan.phone_captured;
    assign o_phone_chars_first = out_data.scan.phone_chars_first;
    assign o_phone_chars_rest  = out_data.scan.phone_chars_rest;
    assign o_line_byte_valid   = out_data.line.line_byte_valid;
    assign o_line_position     = out_data.line.line_position;
    assign o_line_byte         = out_data.line.line_byte;
    assign o_sms_line_done     = out_data.line.sms_line_done;

endmodule
